[src/srpf_pkg.sv]
package srpf_pkg;

	// Positions use the low bits of each coordinate port, at most 32 of them.
	localparam int COORD_WIDTH = 32;
	localparam int PosBits = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam logic [31:0] PosMask = 32'((64'd1 << PosBits) - 64'd1);

	// One root bit per square-root stage, one quotient bit per divider stage.
	localparam int SqrtSteps = 32;
	localparam int DivSteps = 63;

	// Configuration register indexes.
	localparam logic [1:0] RegCutoff = 2'd0;
	localparam logic [1:0] RegMinRadius = 2'd1;
	localparam logic [1:0] RegInvMass = 2'd2;

	localparam logic [63:0] SatPos = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SatNeg = 64'h8000_0000_0000_0000;

	// Geometry of one pair after the distance check and clamp.
	typedef struct packed {
		logic [63:0] r2;
		logic [31:0] xmag;
		logic [31:0] ymag;
		logic        xneg;
		logic        yneg;
		logic        in_range;
		logic        zero;
	} geom_t;

	typedef struct packed {
		logic signed [63:0] ax;
		logic signed [63:0] ay;
		logic               in_range;
	} result_t;

endpackage

[src/short_range_pair_force.sv]
// Short-range repulsive pair force. Each input beat carries the positions of a
// particle and one neighbor (unsigned Q8.24); the block returns one result beat
// with the acceleration increment the neighbor imposes (signed Q40.24, saturated)
// and a flag telling whether the pair lies within the cutoff. Pairs farther apart
// than cutoff_radius give zero increments with the flag cleared; coincident pairs
// with a zero min_radius give zero increments with the flag set. The block is a
// fully pipelined datapath: a new pair is accepted every clock cycle unless the
// output buffer is full. It is built from the 32-stage square root (one root
// bit per stage) and the 63-stage restoring divider (one quotient bit per stage,
// both axes side by side), plus the multiply and compare stages around them. A
// two-entry output buffer takes finished results, so input is taken while a result
// waits; the input stalls only when that buffer is full. Configuration registers
// are written through a simple write port and must only change while no pair is
// in flight.
module short_range_pair_force (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        self_x,
	input  logic [31:0]        self_y,
	input  logic [31:0]        other_x,
	input  logic [31:0]        other_y,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] accel_x_inc,
	output logic signed [63:0] accel_y_inc,
	output logic               within_cutoff,

	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data
);

	// Configuration registers.
	logic [31:0] cutoff_q;
	logic [31:0] min_radius_q;
	logic [31:0] inv_mass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= 32'd167772;
			min_radius_q <= 32'd1678;
			inv_mass_q <= 32'd6553600;
		end else if (wr_en) begin
			unique case (wr_index)
				srpf_pkg::RegCutoff:    cutoff_q <= wr_data;
				srpf_pkg::RegMinRadius: min_radius_q <= wr_data;
				srpf_pkg::RegInvMass:   inv_mass_q <= wr_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together; it holds only while the output buffer
	// is full, so no beat is lost or repeated under a stall.
	logic en;
	logic buf_full;

	assign en = !buf_full;
	assign in_stall = buf_full;

	logic              front_vld;
	srpf_pkg::geom_t   front_geom;
	logic              sqrt_vld;
	srpf_pkg::geom_t   sqrt_geom;
	logic [31:0]       sqrt_root;
	logic              div_vld;
	srpf_pkg::result_t div_res;
	srpf_pkg::result_t out_res;

	// Distances, squares, cutoff test and clamp of r2.
	srpf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_vld        (in_valid),
		.self_x        (self_x),
		.self_y        (self_y),
		.other_x       (other_x),
		.other_y       (other_y),
		.cutoff_radius (cutoff_q),
		.min_radius    (min_radius_q),
		.vld           (front_vld),
		.geom          (front_geom)
	);

	// Integer square root of the clamped r2.
	srpf_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (front_vld),
		.geom_in (front_geom),
		.vld     (sqrt_vld),
		.geom    (sqrt_geom),
		.root    (sqrt_root)
	);

	// Products, division and saturation for both axes.
	srpf_div u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_vld        (sqrt_vld),
		.geom          (sqrt_geom),
		.root          (sqrt_root),
		.cutoff_radius (cutoff_q),
		.inverse_mass  (inv_mass_q),
		.vld           (div_vld),
		.res           (div_res)
	);

	srpf_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (div_vld && en),
		.din    (div_res),
		.stall  (out_stall),
		.valid  (out_valid),
		.dout   (out_res),
		.full   (buf_full)
	);

	assign accel_x_inc = out_res.ax;
	assign accel_y_inc = out_res.ay;
	assign within_cutoff = out_res.in_range;

endmodule

[src/srpf_front.sv]
module srpf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [31:0]       self_x,
	input  logic [31:0]       self_y,
	input  logic [31:0]       other_x,
	input  logic [31:0]       other_y,
	input  logic [31:0]       cutoff_radius,
	input  logic [31:0]       min_radius,
	output logic              vld,
	output srpf_pkg::geom_t   geom
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic [31:0] sx_s1, sy_s1, ox_s1, oy_s1;
	logic [31:0] xmag_s2, ymag_s2;
	logic xneg_s2, yneg_s2;
	logic [31:0] xmag_s3, ymag_s3;
	logic xneg_s3, yneg_s3;
	logic [63:0] x2_s3, y2_s3, c2_s3, m2_s3;
	srpf_pkg::geom_t geom_s4;

	logic [63:0] x2_c, y2_c, c2_c, m2_c;
	logic [64:0] sum_c;

	assign x2_c = xmag_s2 * xmag_s2;
	assign y2_c = ymag_s2 * ymag_s2;
	assign c2_c = cutoff_radius * cutoff_radius;
	assign m2_c = min_radius * min_radius;
	assign sum_c = {1'b0, x2_s3} + {1'b0, y2_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= self_x & srpf_pkg::PosMask;
			sy_s1 <= self_y & srpf_pkg::PosMask;
			ox_s1 <= other_x & srpf_pkg::PosMask;
			oy_s1 <= other_y & srpf_pkg::PosMask;

			xneg_s2 <= ox_s1 < sx_s1;
			yneg_s2 <= oy_s1 < sy_s1;
			xmag_s2 <= (ox_s1 < sx_s1) ? sx_s1 - ox_s1 : ox_s1 - sx_s1;
			ymag_s2 <= (oy_s1 < sy_s1) ? sy_s1 - oy_s1 : oy_s1 - sy_s1;

			xneg_s3 <= xneg_s2;
			yneg_s3 <= yneg_s2;
			xmag_s3 <= xmag_s2;
			ymag_s3 <= ymag_s2;
			x2_s3 <= x2_c;
			y2_s3 <= y2_c;
			c2_s3 <= c2_c;
			m2_s3 <= m2_c;

			geom_s4.xneg <= xneg_s3;
			geom_s4.yneg <= yneg_s3;
			geom_s4.xmag <= xmag_s3;
			geom_s4.ymag <= ymag_s3;
			geom_s4.in_range <= sum_c <= {1'b0, c2_s3};
			geom_s4.r2 <= (sum_c[63:0] < m2_s3) ? m2_s3 : sum_c[63:0];
			geom_s4.zero <= (x2_s3 == 64'd0) && (y2_s3 == 64'd0) && (m2_s3 == 64'd0);
		end
	end

	assign vld = v_s4;
	assign geom = geom_s4;

endmodule

[src/srpf_sqrt.sv]
module srpf_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  srpf_pkg::geom_t   geom_in,
	output logic              vld,
	output srpf_pkg::geom_t   geom,
	output logic [31:0]       root
);

	logic            vld_s  [srpf_pkg::SqrtSteps];
	srpf_pkg::geom_t geom_s [srpf_pkg::SqrtSteps];
	logic [32:0]     rem_s  [srpf_pkg::SqrtSteps];
	logic [31:0]     q_s    [srpf_pkg::SqrtSteps];

	// Restoring digit-by-digit root: each stage brings down two bits of r2.
	for (genvar k = 0; k < srpf_pkg::SqrtSteps; k++) begin : g_st
		logic            vi;
		srpf_pkg::geom_t gi;
		logic [32:0]     ri;
		logic [31:0]     qi;
		logic [34:0]     sh;
		logic [34:0]     tr;
		logic            ge;

		if (k == 0) begin : g_first
			assign vi = in_vld;
			assign gi = geom_in;
			assign ri = '0;
			assign qi = '0;
		end else begin : g_next
			assign vi = vld_s[k-1];
			assign gi = geom_s[k-1];
			assign ri = rem_s[k-1];
			assign qi = q_s[k-1];
		end

		assign sh = {ri, gi.r2[2*(srpf_pkg::SqrtSteps-1-k)+1 -: 2]};
		assign tr = {1'b0, qi, 2'b01};
		assign ge = sh >= tr;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				geom_s[k] <= gi;
				rem_s[k] <= ge ? 33'(sh - tr) : sh[32:0];
				q_s[k] <= {qi[30:0], ge};
			end
		end
	end

	assign vld = vld_s[srpf_pkg::SqrtSteps-1];
	assign geom = geom_s[srpf_pkg::SqrtSteps-1];
	assign root = q_s[srpf_pkg::SqrtSteps-1];

endmodule

[src/srpf_div.sv]
module srpf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  srpf_pkg::geom_t   geom,
	input  logic [31:0]       root,
	input  logic [31:0]       cutoff_radius,
	input  logic [31:0]       inverse_mass,
	output logic              vld,
	output srpf_pkg::result_t res
);

	typedef struct packed {
		logic       in_range;
		logic       zero;
		logic [1:0] neg;
		logic [1:0] ovf;
	} flags_t;

	// Front end: numerator (r - cutoff) * d * inverse_mass and denominator r * r2.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	srpf_pkg::geom_t g_s1;
	logic [31:0] r_s1;
	logic rcneg_s1;
	logic [31:0] rcmag_s1;
	flags_t f_s2, f_s3, f_s4, f_s5;
	logic [63:0] p_s2 [2];
	logic [63:0] dlo_s2, dhi_s2;
	logic [63:0] n0_s3 [2];
	logic [63:0] n1_s3 [2];
	logic [95:0] den_s3, den_s4, den_s5;
	logic [95:0] num_s4 [2];
	logic [95:0] rem_s5 [2];
	logic [62:0] low_s5 [2];

	logic [63:0] p_c [2];
	logic [63:0] dlo_c, dhi_c;
	logic [63:0] n0_c [2];
	logic [63:0] n1_c [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			p_c[l] = rcmag_s1 * ((l == 0) ? g_s1.xmag : g_s1.ymag);
			n0_c[l] = p_s2[l][31:0] * inverse_mass;
			n1_c[l] = p_s2[l][63:32] * inverse_mass;
		end
	end

	assign dlo_c = r_s1 * g_s1.r2[31:0];
	assign dhi_c = r_s1 * g_s1.r2[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= geom;
			r_s1 <= root;
			rcneg_s1 <= root < cutoff_radius;
			rcmag_s1 <= (root < cutoff_radius) ? cutoff_radius - root : root - cutoff_radius;

			f_s2.in_range <= g_s1.in_range;
			f_s2.zero <= g_s1.zero;
			f_s2.neg <= {rcneg_s1 ^ g_s1.yneg, rcneg_s1 ^ g_s1.xneg};
			f_s2.ovf <= 2'b00;
			dlo_s2 <= dlo_c;
			dhi_s2 <= dhi_c;

			f_s3 <= f_s2;
			den_s3 <= {32'd0, dlo_s2} + {dhi_s2, 32'd0};

			f_s4 <= f_s3;
			den_s4 <= den_s3;

			f_s5.in_range <= f_s4.in_range;
			f_s5.zero <= f_s4.zero;
			f_s5.neg <= f_s4.neg;
			den_s5 <= den_s4;

			for (int l = 0; l < 2; l++) begin
				p_s2[l] <= p_c[l];
				n0_s3[l] <= n0_c[l];
				n1_s3[l] <= n1_c[l];
				num_s4[l] <= {32'd0, n0_s3[l]} + {n1_s3[l], 32'd0};
				// The quotient of (num << 32) by den is below 2^63 exactly when
				// the top 65 dividend bits are below den; those bits seed the remainder.
				f_s5.ovf[l] <= {31'd0, num_s4[l][95:31]} >= den_s4;
				rem_s5[l] <= {31'd0, num_s4[l][95:31]};
				low_s5[l] <= {num_s4[l][30:0], 32'd0};
			end
		end
	end

	// Restoring divider, one quotient bit per stage for both lanes.
	logic        dv_s   [srpf_pkg::DivSteps];
	flags_t      df_s   [srpf_pkg::DivSteps];
	logic [95:0] dden_s [srpf_pkg::DivSteps];
	logic [95:0] drem_s [srpf_pkg::DivSteps][2];
	logic [62:0] dlow_s [srpf_pkg::DivSteps][2];
	logic [62:0] dq_s   [srpf_pkg::DivSteps][2];

	for (genvar k = 0; k < srpf_pkg::DivSteps; k++) begin : g_st
		logic        vi;
		flags_t      fi;
		logic [95:0] di;
		logic [95:0] ri [2];
		logic [62:0] li [2];
		logic [62:0] qi [2];
		logic [96:0] sh [2];
		logic        ge [2];

		if (k == 0) begin : g_first
			assign vi = v_s5;
			assign fi = f_s5;
			assign di = den_s5;
			assign ri = rem_s5;
			assign li = low_s5;
			assign qi = '{63'd0, 63'd0};
		end else begin : g_next
			assign vi = dv_s[k-1];
			assign fi = df_s[k-1];
			assign di = dden_s[k-1];
			assign ri = drem_s[k-1];
			assign li = dlow_s[k-1];
			assign qi = dq_s[k-1];
		end

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				sh[l] = {ri[l], li[l][62]};
				ge[l] = sh[l] >= {1'b0, di};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (en) begin
				dv_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				df_s[k] <= fi;
				dden_s[k] <= di;
				for (int l = 0; l < 2; l++) begin
					drem_s[k][l] <= ge[l] ? 96'(sh[l] - {1'b0, di}) : sh[l][95:0];
					dlow_s[k][l] <= {li[l][61:0], 1'b0};
					dq_s[k][l] <= {qi[l][61:0], ge[l]};
				end
			end
		end
	end

	// Sign, saturation and the no-force cases.
	localparam int Last = srpf_pkg::DivSteps - 1;

	logic v_sn;
	srpf_pkg::result_t res_sn;
	logic [63:0] mag_c [2];
	logic [63:0] val_c [2];
	logic        kill_c;

	assign kill_c = !df_s[Last].in_range || df_s[Last].zero;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (df_s[Last].ovf[l]) begin
				mag_c[l] = df_s[Last].neg[l] ? srpf_pkg::SatNeg : srpf_pkg::SatPos;
			end else begin
				mag_c[l] = {1'b0, dq_s[Last][l]};
			end
			val_c[l] = df_s[Last].neg[l] ? 64'd0 - mag_c[l] : mag_c[l];
			if (kill_c) begin
				val_c[l] = 64'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (en) begin
			v_sn <= dv_s[Last];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sn.ax <= val_c[0];
			res_sn.ay <= val_c[1];
			res_sn.in_range <= df_s[Last].in_range;
		end
	end

	assign vld = v_sn;
	assign res = res_sn;

endmodule

[src/srpf_outbuf.sv]
module srpf_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  srpf_pkg::result_t din,
	input  logic              stall,
	output logic              valid,
	output srpf_pkg::result_t dout,
	output logic              full
);

	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	srpf_pkg::result_t mem_q [2];
	logic pop;

	assign valid = cnt_q != 2'd0;
	assign full = cnt_q == 2'd2;
	assign pop = valid && !stall;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

[src/srpf_checker.sv]
module srpf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [63:0] accel_x_inc,
	input logic signed [63:0] accel_y_inc,
	input logic               within_cutoff
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	// A stalled result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(accel_x_inc) && $stable(accel_y_inc)
			&& $stable(within_cutoff))
		else $error("result payload changed under stall");

	// Pairs beyond the cutoff carry no force.
	a_cut_zero: assert property (@(posedge clk)
		out_valid && !within_cutoff |-> accel_x_inc == 64'sd0 && accel_y_inc == 64'sd0)
		else $error("nonzero increment beyond cutoff");

	// With nothing waiting at the output, input is always taken.
	a_no_idle_stall: assert property (@(posedge clk)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output buffer");

endmodule

bind short_range_pair_force srpf_checker u_srpf_checker (.*);

[tb/sv/short_range_pair_force_test.sv]
module short_range_pair_force_test;

	// Datapath depth from an accepted pair to its result.
	localparam int PipeDepth = 105;
	localparam int SettleCycles = 2 * PipeDepth;
	// Cycles with work pending but no beat accepted on either side before giving up.
	localparam int StuckLimit = 4000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [31:0]        self_x;
	logic [31:0]        self_y;
	logic [31:0]        other_x;
	logic [31:0]        other_y;
	logic               out_valid;
	logic               out_stall;
	logic signed [63:0] accel_x_inc;
	logic signed [63:0] accel_y_inc;
	logic               within_cutoff;
	logic               wr_en;
	logic [1:0]         wr_index;
	logic [31:0]        wr_data;

	short_range_pair_force i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.self_x(self_x),
		.self_y(self_y),
		.other_x(other_x),
		.other_y(other_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accel_x_inc(accel_x_inc),
		.accel_y_inc(accel_y_inc),
		.within_cutoff(within_cutoff),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Our own copy of the three registers, tracking every write we make.
	logic [31:0] cutoff_reg;
	logic [31:0] min_radius_reg;
	logic [31:0] inv_mass_reg;

	// Forces predicted for accepted pairs, oldest first.
	srpf_pkg::result_t pending_forces[$];

	int mismatches = 0;
	int pairs_sent = 0;
	int forces_checked = 0;
	int interacting_seen = 0;
	int phases_run = 0;
	// When set, both sides run back to back with no idle cycles.
	bit no_idle = 0;
	int stuck_cycles = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Floor of the square root, one root bit at a time from the top.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] root;
		logic [63:0] trial;
		root = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= x) root = trial;
		end
		return root;
	endfunction

	// One axis of the increment: (r - cutoff) * d * inv_mass / (r * r2) in Q40.24,
	// truncated toward zero and clipped to the signed 64-bit range.
	function automatic logic [63:0] axis_increment(input logic [63:0] r,
			input logic [63:0] r2, input logic [31:0] d_mag, input logic d_neg);
		logic         rc_neg;
		logic [63:0]  rc_mag;
		logic         neg;
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] quo;
		logic [63:0]  clip;
		rc_neg = r < {32'd0, cutoff_reg};
		rc_mag = rc_neg ? {32'd0, cutoff_reg} - r : r - {32'd0, cutoff_reg};
		neg = rc_neg != d_neg;
		num = ((128'(rc_mag) * 128'(d_mag)) * 128'(inv_mass_reg)) << 32;
		den = 128'(r) * 128'(r2);
		quo = num / den;
		clip = neg ? srpf_pkg::SatNeg : srpf_pkg::SatPos;
		if (quo > 128'(clip)) quo = 128'(clip);
		return neg ? 64'd0 - quo[63:0] : quo[63:0];
	endfunction

	function automatic srpf_pkg::result_t predict_force(input logic [31:0] sx,
			input logic [31:0] sy, input logic [31:0] ox, input logic [31:0] oy);
		srpf_pkg::result_t res;
		logic        xneg;
		logic        yneg;
		logic [31:0] xmag;
		logic [31:0] ymag;
		logic [63:0] c2;
		logic [63:0] m2;
		logic [63:0] x2;
		logic [63:0] y2;
		logic [63:0] r2;
		logic [63:0] r;
		sx = sx & srpf_pkg::PosMask;
		sy = sy & srpf_pkg::PosMask;
		ox = ox & srpf_pkg::PosMask;
		oy = oy & srpf_pkg::PosMask;
		xneg = ox < sx;
		yneg = oy < sy;
		xmag = xneg ? sx - ox : ox - sx;
		ymag = yneg ? sy - oy : oy - sy;
		c2 = 64'(cutoff_reg) * 64'(cutoff_reg);
		m2 = 64'(min_radius_reg) * 64'(min_radius_reg);
		x2 = 64'(xmag) * 64'(xmag);
		y2 = 64'(ymag) * 64'(ymag);
		res.ax = 0;
		res.ay = 0;
		res.in_range = 1'b0;
		// The two-step compare keeps r2 from overflowing on far pairs.
		if (x2 > c2 || y2 > c2 - x2) return res;
		res.in_range = 1'b1;
		r2 = x2 + y2;
		if (r2 < m2) r2 = m2;
		// Coincident particles with no minimum radius have no defined force.
		if (r2 == 0) return res;
		r = floor_sqrt(r2);
		res.ax = axis_increment(r, r2, xmag, xneg);
		res.ay = axis_increment(r, r2, ymag, yneg);
		return res;
	endfunction

	function automatic int idle_cycles();
		return no_idle ? 0 : $urandom_range(0, 18);
	endfunction

	// Send one pair. Entered and left at a falling edge; valid stays high on exit so
	// that a following beat with no gap keeps it high without a glitch.
	task automatic send_pair(input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] ox, input logic [31:0] oy);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		self_x = sx;
		self_y = sy;
		other_x = ox;
		other_y = oy;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		pending_forces.insert(pending_forces.size(), predict_force(sx, sy, ox, oy));
		pairs_sent++;
		@(negedge clk);
	endtask

	task automatic wait_all_forces();
		in_valid = 1'b0;
		while (pending_forces.size() != 0) @(negedge clk);
	endtask

	// Registers change only with the pipe empty, so drain it and let it settle.
	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		wait_all_forces();
		repeat (SettleCycles) @(negedge clk);
		wr_en = 1'b1;
		wr_index = index;
		wr_data = value;
		@(negedge clk);
		wr_en = 1'b0;
		case (index)
			srpf_pkg::RegCutoff: cutoff_reg = value;
			srpf_pkg::RegMinRadius: min_radius_reg = value;
			srpf_pkg::RegInvMass: inv_mass_reg = value;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] cutoff, input logic [31:0] minr,
			input logic [31:0] invm);
		write_reg(srpf_pkg::RegCutoff, cutoff);
		write_reg(srpf_pkg::RegMinRadius, minr);
		write_reg(srpf_pkg::RegInvMass, invm);
		phases_run++;
	endtask

	// A neighbor placed at a signed offset from the particle, wrapping like the port.
	task automatic send_offset(input logic [31:0] sx, input logic [31:0] sy,
			input longint dx, input longint dy);
		send_pair(sx, sy, 32'(longint'(sx) + dx), 32'(longint'(sy) + dy));
	endtask

	// Extremes of the coordinates and the named corner cases at the reset settings.
	task automatic test_reset_settings();
		send_pair(32'd0, 32'd0, 32'd0, 32'd0);
		send_pair('1, '1, '1, '1);
		send_pair(32'd0, 32'd0, '1, '1);
		send_pair('1, '1, 32'd0, 32'd0);
		send_pair(32'h0100_0000, 32'h0100_0000, 32'h0100_0000 + 32'd167772, 32'h0100_0000);
		send_pair(32'h0100_0000, 32'h0100_0000, 32'h0100_0000 - 32'd167772, 32'h0100_0000);
		send_pair(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000 + 32'd167773);
		send_offset(32'h0200_0000, 32'h0200_0000, 100, -50);
		send_offset(32'h0200_0000, 32'h0200_0000, -1000, 1000);
		send_offset(32'h0200_0000, 32'h0200_0000, 118000, -118000);
		send_offset(32'h0200_0000, 32'h0200_0000, 118700, 118700);
		send_offset(32'h0200_0000, 32'h0200_0000, -30000, -5);
	endtask

	// No minimum radius: coincident particles give zero force with the flag set.
	task automatic test_zero_min_radius();
		set_regs(32'd167772, 32'd0, 32'd6553600);
		send_pair(32'h1234_5678, 32'h0ABC_DEF0, 32'h1234_5678, 32'h0ABC_DEF0);
		send_offset(32'h0400_0000, 32'h0400_0000, 1, 0);
		send_offset(32'h0400_0000, 32'h0400_0000, 0, -1);
	endtask

	// Minimum radius beyond the cutoff turns the force attractive.
	task automatic test_attractive();
		set_regs(32'd1000, 32'd50000, 32'd65536);
		send_offset(32'h0300_0000, 32'h0300_0000, 10, 20);
		send_offset(32'h0300_0000, 32'h0300_0000, -700, 700);
		send_offset(32'h0300_0000, 32'h0300_0000, 0, 0);
	endtask

	// Widest cutoff and heaviest inverse mass, which can drive an axis into saturation, then settings of 1.
	task automatic test_saturation();
		set_regs('1, 32'd1, '1);
		send_pair(32'd0, 32'd0, 32'd1, 32'd0);
		send_pair(32'd1, 32'd1, 32'd0, 32'd0);
		send_pair(32'd0, 32'd0, '1, 32'd0);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0100, 32'h7FFF_FF00);
		set_regs(32'd1, 32'd1, 32'd1);
		send_pair(32'd5, 32'd5, 32'd6, 32'd5);
		send_pair(32'd5, 32'd5, 32'd6, 32'd6);
	endtask

	// Random pairs under one register setting. Most neighbors fall inside the cutoff
	// so the force path is exercised; two in ten pairs use arbitrary coordinates that
	// also toggle every port bit.
	task automatic test_random_phase(input logic [31:0] cutoff, input logic [31:0] minr,
			input logic [31:0] invm, input int count, input bit hold_midway);
		logic [31:0] sx;
		logic [31:0] sy;
		longint span;
		set_regs(cutoff, minr, invm);
		span = longint'(cutoff) + 2;
		for (int n = 0; n < count; n++) begin
			if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
			// Hold the sender once until every predicted force has come back.
			if (hold_midway && n == count / 2) wait_all_forces();
			sx = $urandom();
			sy = $urandom();
			case ($urandom_range(0, 9))
				0, 1: send_pair(sx, sy, $urandom(), $urandom());
				2: send_offset(sx, sy, longint'($urandom_range(0, 16)) - 8,
						longint'($urandom_range(0, 16)) - 8);
				default: send_offset(sx, sy,
						(longint'($urandom()) % (2 * span)) - span,
						(longint'($urandom()) % (2 * span)) - span);
			endcase
		end
		no_idle = 1'b0;
	endtask

	// Result side: random stall per beat, and every accepted beat is checked against
	// the oldest prediction.
	initial begin
		int hold;
		srpf_pkg::result_t want;
		out_stall = 1'b1;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = idle_cycles();
			out_stall = hold > 0;
			repeat (hold) @(negedge clk);
			out_stall = 1'b0;
			forever begin
				@(posedge clk);
				if (out_valid) break;
			end
			if (pending_forces.size() == 0) begin
				$error("result beat with no pair outstanding");
				mismatches++;
			end else begin
				want = pending_forces.pop_front();
				forces_checked++;
				if (want.in_range) interacting_seen++;
				if (accel_x_inc !== want.ax) begin
					$error("accel_x_inc: expected %0d, got %0d", want.ax, accel_x_inc);
					mismatches++;
				end
				if (accel_y_inc !== want.ay) begin
					$error("accel_y_inc: expected %0d, got %0d", want.ay, accel_y_inc);
					mismatches++;
				end
				if (within_cutoff !== want.in_range) begin
					$error("within_cutoff: expected %0b, got %0b", want.in_range,
						within_cutoff);
					mismatches++;
				end
			end
			@(negedge clk);
		end
	end

	// Watchdog: work is pending but neither side has moved a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else if (in_valid || pending_forces.size() != 0) begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= StuckLimit) begin
				$display("watchdog expired with %0d results outstanding",
					pending_forces.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		self_x = '0;
		self_y = '0;
		other_x = '0;
		other_y = '0;
		wr_en = 1'b0;
		wr_index = srpf_pkg::RegCutoff;
		wr_data = '0;
		cutoff_reg = 32'd167772;
		min_radius_reg = 32'd1678;
		inv_mass_reg = 32'd6553600;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_settings();
		test_zero_min_radius();
		test_attractive();
		test_saturation();
		test_random_phase(32'd167772, 32'd1678, 32'd6553600, 230, 1'b1);
		test_random_phase('1, '1, '1, 220, 1'b0);
		test_random_phase(32'd1, 32'd0, 32'd1, 220, 1'b0);
		test_random_phase($urandom(), $urandom_range(0, 4096), $urandom(), 230, 1'b0);
		test_random_phase($urandom_range(1, 32'h0100_0000), $urandom_range(1, 65536),
			$urandom_range(1, 32'h00FF_FFFF), 230, 1'b0);

		wait_all_forces();
		repeat (SettleCycles) @(negedge clk);
		$display("sent %0d pairs over %0d register settings; %0d results checked,",
			pairs_sent, phases_run + 1, forces_checked);
		$display("%0d of them inside the cutoff, %0d field mismatches", interacting_seen,
			mismatches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
